// ===== sv/msd_pkg.sv =====
// ----------------------------------------------------------------------------
// msd_pkg
// Shared types and constants for the microprogrammed stack datapath.
// ----------------------------------------------------------------------------
package msd_pkg;

  localparam int MEM_WORDS = 16;
  localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int NUM_REGS  = 9;

  // Word register slots, in C-bus enable bit order
  localparam int RG_MAR = 0;
  localparam int RG_MDR = 1;
  localparam int RG_PC  = 2;
  localparam int RG_SP  = 3;
  localparam int RG_LV  = 4;
  localparam int RG_CPP = 5;
  localparam int RG_TOS = 6;
  localparam int RG_OPC = 7;
  localparam int RG_H   = 8;

  // Item function codes
  localparam logic [1:0] FN_EXEC     = 2'd0;
  localparam logic [1:0] FN_LOAD_REG = 2'd1;
  localparam logic [1:0] FN_LOAD_MEM = 2'd2;

  // B bus source codes
  localparam logic [3:0] BS_MDR  = 4'd0;
  localparam logic [3:0] BS_PC   = 4'd1;
  localparam logic [3:0] BS_MBRS = 4'd2;
  localparam logic [3:0] BS_MBRU = 4'd3;
  localparam logic [3:0] BS_SP   = 4'd4;
  localparam logic [3:0] BS_LV   = 4'd5;
  localparam logic [3:0] BS_CPP  = 4'd6;
  localparam logic [3:0] BS_TOS  = 4'd7;
  localparam logic [3:0] BS_OPC  = 4'd8;

  // Preload target codes
  localparam logic [3:0] LD_MAR = 4'd0;
  localparam logic [3:0] LD_MDR = 4'd1;
  localparam logic [3:0] LD_PC  = 4'd2;
  localparam logic [3:0] LD_MBR = 4'd3;
  localparam logic [3:0] LD_SP  = 4'd4;
  localparam logic [3:0] LD_LV  = 4'd5;
  localparam logic [3:0] LD_CPP = 4'd6;
  localparam logic [3:0] LD_TOS = 4'd7;
  localparam logic [3:0] LD_OPC = 4'd8;
  localparam logic [3:0] LD_H   = 4'd9;

  // ALU function codes (F0,F1)
  localparam logic [1:0] ALU_AND  = 2'd0;
  localparam logic [1:0] ALU_OR   = 2'd1;
  localparam logic [1:0] ALU_PASS = 2'd2;
  localparam logic [1:0] ALU_ADD  = 2'd3;

  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 304;

  typedef logic [NUM_REGS-1:0][31:0] word_arr_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  alu_ctrl;
    logic [8:0]  c_enables;
    logic        mem_write;
    logic        mem_read;
    logic [3:0]  b_select;
    logic [3:0]  load_index;
    logic [31:0] load_value;
  } item_t;

  typedef struct packed {
    logic        zero_flag;
    logic        neg_flag;
    logic [7:0]  mbr;
    word_arr_t   regs;
  } result_t;

endpackage

// ===== sv/microprogrammed_stack_datapath.sv =====
// ----------------------------------------------------------------------------
// microprogrammed_stack_datapath
// Stack-machine datapath running one microinstruction or preload per item.
// ----------------------------------------------------------------------------
// Input channel (in_*): one item per transfer. in_tuser carries the function
// (execute, preload register, preload memory word); in_tdata carries the
// microinstruction fields and the preload index and value.
// Output channel (out_*): exactly one result per item, in order, holding all
// word registers, the byte register and the ALU flags after that item.
// An accepted item sits in an input register; once the output register is
// free or draining, the register file, ALU and 16-word memory compute the
// step in one pass and the result is captured in the output register,
// which raises out_tvalid. Throughput is one item per cycle while the
// receiver does not stall, bounded by the combinational path through B mux,
// ALU, C bus and memory port.
// Reset clears the architectural registers and valid flags, marks every word
// of memory as zero; no clearing pass is needed, items are accepted at once.
// When the receiver stalls, the result holds in the output register, one
// more item waits in the input register, and then in_tready drops.
// ----------------------------------------------------------------------------
module microprogrammed_stack_datapath (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [7:0] alu_ctrl, [16:8] c_enables, [17] mem_write, [18] mem_read,
  // [22:19] b_select, [26:23] load_index, [58:27] load_value, rest zero
  input  logic [63:0]  in_tdata,
  // [1:0] func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] h_out, [63:32] opc_out, [95:64] tos_out, [127:96] cpp_out,
  // [159:128] lv_out, [191:160] sp_out, [223:192] pc_out, [255:224] mdr_out,
  // [287:256] mar_out, [295:288] mbr_out, [296] neg_flag, [297] zero_flag
  output logic [303:0] out_tdata
);
  import msd_pkg::*;

  item_t       item_r;
  logic        item_v_r;
  logic        out_v_r;
  logic [303:0] out_data_r;
  logic        exec;
  result_t     res;

  // Execute the held item when the output slot is free or draining
  assign exec      = item_v_r & (~out_v_r | out_tready);
  assign in_tready = ~item_v_r | exec;

  msd_state u_state (
    .clk   (clk),
    .rst_n (rst_n),
    .exec  (exec),
    .item  (item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_v_r <= in_tvalid;
      end
      if (exec) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.func       <= in_tuser;
      item_r.alu_ctrl   <= in_tdata[7:0];
      item_r.c_enables  <= in_tdata[16:8];
      item_r.mem_write  <= in_tdata[17];
      item_r.mem_read   <= in_tdata[18];
      item_r.b_select   <= in_tdata[22:19];
      item_r.load_index <= in_tdata[26:23];
      item_r.load_value <= in_tdata[58:27];
    end
    if (exec) begin
      out_data_r <= {6'd0, res.zero_flag, res.neg_flag, res.mbr,
                     res.regs[RG_MAR], res.regs[RG_MDR], res.regs[RG_PC],
                     res.regs[RG_SP], res.regs[RG_LV], res.regs[RG_CPP],
                     res.regs[RG_TOS], res.regs[RG_OPC], res.regs[RG_H]};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== sv/msd_alu.sv =====
// ----------------------------------------------------------------------------
// msd_alu
// B bus source select and the ALU with its output shifter.
// ----------------------------------------------------------------------------
module msd_alu (
  input  msd_pkg::word_arr_t regs,
  input  logic [7:0]         mbr,
  input  logic [3:0]         b_select,
  input  logic [7:0]         alu_ctrl,
  output logic [31:0]        alu_res
);
  import msd_pkg::*;

  logic [31:0] b_bus;
  logic [31:0] a_op;
  logic [31:0] b_op;
  logic [31:0] f_res;

  always_comb begin
    case (b_select)
      BS_MDR:  b_bus = regs[RG_MDR];
      BS_PC:   b_bus = regs[RG_PC];
      BS_MBRS: b_bus = {{24{mbr[7]}}, mbr};
      BS_MBRU: b_bus = {24'd0, mbr};
      BS_SP:   b_bus = regs[RG_SP];
      BS_LV:   b_bus = regs[RG_LV];
      BS_CPP:  b_bus = regs[RG_CPP];
      BS_TOS:  b_bus = regs[RG_TOS];
      BS_OPC:  b_bus = regs[RG_OPC];
      default: b_bus = 32'd0;
    endcase
  end

  always_comb begin
    a_op = alu_ctrl[3] ? regs[RG_H] : 32'd0;
    if (alu_ctrl[1]) begin
      a_op = ~a_op;
    end
    b_op = alu_ctrl[2] ? b_bus : 32'd0;
    case (alu_ctrl[5:4])
      ALU_AND:  f_res = a_op & b_op;
      ALU_OR:   f_res = a_op | b_op;
      ALU_PASS: f_res = b_op;
      ALU_ADD:  f_res = a_op + b_op + {31'd0, alu_ctrl[0]};
      default:  f_res = 32'd0;
    endcase
    // SLL8 wins over SRA1
    if (alu_ctrl[7]) begin
      alu_res = {f_res[23:0], 8'd0};
    end else if (alu_ctrl[6]) begin
      alu_res = {f_res[31], f_res[31:1]};
    end else begin
      alu_res = f_res;
    end
  end

endmodule

// ===== sv/msd_state.sv =====
// ----------------------------------------------------------------------------
// msd_state
// Architectural registers and data memory; computes one step per transfer.
// ----------------------------------------------------------------------------
module msd_state (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             exec,
  input  msd_pkg::item_t   item,
  output msd_pkg::result_t res
);
  import msd_pkg::*;

  word_arr_t   regs_r;
  word_arr_t   regs_nxt;
  logic [7:0]  mbr_r;
  logic [7:0]  mbr_nxt;
  logic [31:0] mem_r [MEM_WORDS];
  logic [MEM_WORDS-1:0] mem_v_r;

  logic [31:0]       alu_res;
  logic              rd_wr;
  logic              alu_run;
  logic [31:0]       mar_nxt;
  logic              addr_ok;
  logic [MEM_AW-1:0] addr;
  logic [31:0]       rdata;
  logic              mem_we;
  logic [MEM_AW-1:0] mem_wa;
  logic [31:0]       mem_wd;
  logic              neg;
  logic              zero;

  msd_alu u_alu (
    .regs     (regs_r),
    .mbr      (mbr_r),
    .b_select (item.b_select),
    .alu_ctrl (item.alu_ctrl),
    .alu_res  (alu_res)
  );

  assign rd_wr   = item.mem_read & item.mem_write;
  assign alu_run = (item.func == FN_EXEC) & ~rd_wr;
  assign mar_nxt = (alu_run & item.c_enables[RG_MAR]) ? alu_res : regs_r[RG_MAR];
  assign addr_ok = mar_nxt < 32'(MEM_WORDS);
  assign addr    = mar_nxt[MEM_AW-1:0];
  // Unwritten words read as their reset value of zero
  assign rdata   = (addr_ok && mem_v_r[addr]) ? mem_r[addr] : 32'd0;

  always_comb begin
    regs_nxt = regs_r;
    mbr_nxt  = mbr_r;
    neg      = 1'b0;
    zero     = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = addr;
    mem_wd   = 32'd0;
    case (item.func)
      FN_EXEC: begin
        if (alu_run) begin
          for (int i = 0; i < NUM_REGS; i++) begin
            if (item.c_enables[i]) begin
              regs_nxt[i] = alu_res;
            end
          end
          neg  = alu_res[31];
          zero = (alu_res == 32'd0);
        end
        if (addr_ok) begin
          if (rd_wr) begin
            mbr_nxt        = item.alu_ctrl;
            regs_nxt[RG_H] = {24'd0, item.alu_ctrl};
          end else if (item.mem_read) begin
            regs_nxt[RG_MDR] = rdata;
          end else if (item.mem_write) begin
            mem_we = 1'b1;
            mem_wd = regs_nxt[RG_MDR];
          end
        end
      end
      FN_LOAD_REG: begin
        case (item.load_index)
          LD_MAR:  regs_nxt[RG_MAR] = item.load_value;
          LD_MDR:  regs_nxt[RG_MDR] = item.load_value;
          LD_PC:   regs_nxt[RG_PC]  = item.load_value;
          LD_MBR:  mbr_nxt          = item.load_value[7:0];
          LD_SP:   regs_nxt[RG_SP]  = item.load_value;
          LD_LV:   regs_nxt[RG_LV]  = item.load_value;
          LD_CPP:  regs_nxt[RG_CPP] = item.load_value;
          LD_TOS:  regs_nxt[RG_TOS] = item.load_value;
          LD_OPC:  regs_nxt[RG_OPC] = item.load_value;
          LD_H:    regs_nxt[RG_H]   = item.load_value;
          default: ;
        endcase
      end
      FN_LOAD_MEM: begin
        if ({28'd0, item.load_index} < 32'(MEM_WORDS)) begin
          mem_we = 1'b1;
          mem_wa = MEM_AW'(item.load_index);
          mem_wd = item.load_value;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r  <= '0;
      mbr_r   <= 8'd0;
      mem_v_r <= '0;
    end else if (exec) begin
      regs_r <= regs_nxt;
      mbr_r  <= mbr_nxt;
      if (mem_we) begin
        mem_v_r[mem_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
  end

  assign res.regs      = regs_nxt;
  assign res.mbr       = mbr_nxt;
  assign res.neg_flag  = neg;
  assign res.zero_flag = zero;

endmodule

// ===== dv/microprogrammed_stack_datapath_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// microprogrammed_stack_datapath_test
// Drives preloads, microinstructions and idle items into the datapath over
// the input stream and checks every register, the byte register and the ALU
// flags of each result against a local model of the datapath, with random
// gaps on the sender side and random stalls on the receiver side.
// ----------------------------------------------------------------------------
module microprogrammed_stack_datapath_test;
  import msd_pkg::*;

  localparam logic [1:0] FN_IDLE    = 2'd3;
  localparam int         CYCLE_CAP  = 400000;
  localparam int         TAIL_WAIT  = 6;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [303:0] out_tdata;

  // datapath state as seen by the checker
  logic [31:0]  dp_regs [NUM_REGS];
  logic [7:0]   dp_mbr;
  logic [31:0]  dp_mem [MEM_WORDS];

  logic [303:0] expected_states [$];
  int           send_idle_pct;
  int           recv_idle_pct;
  int           fail_count;
  int           cycles;

  string word_names [NUM_REGS] = '{"h_out", "opc_out", "tos_out", "cpp_out", "lv_out",
                                   "sp_out", "pc_out", "mdr_out", "mar_out"};

  microprogrammed_stack_datapath i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] alu_word(int sll8, int sra1, logic [1:0] fn,
                                          int ena, int enb, int inva, int inc);
    return {sll8[0], sra1[0], fn, ena[0], enb[0], inva[0], inc[0]};
  endfunction

  function automatic item_t mk_exec(logic [7:0] ctl, logic [8:0] cen, int wr, int rd,
                                    logic [3:0] bsel);
    item_t it;
    it = '0;
    it.func      = FN_EXEC;
    it.alu_ctrl  = ctl;
    it.c_enables = cen;
    it.mem_write = wr[0];
    it.mem_read  = rd[0];
    it.b_select  = bsel;
    return it;
  endfunction

  function automatic item_t mk_load(logic [1:0] fn, logic [3:0] idx, logic [31:0] val);
    item_t it;
    it = '0;
    it.func       = fn;
    it.load_index = idx;
    it.load_value = val;
    return it;
  endfunction

  // Apply one item to the local datapath state and return the result word.
  function automatic logic [303:0] step_datapath(item_t it);
    logic [31:0]       bus;
    logic [31:0]       a;
    logic [31:0]       b;
    logic [31:0]       r;
    logic [MEM_AW-1:0] addr;
    logic              neg;
    logic              zero;
    logic [303:0]      snap;
    neg  = 1'b0;
    zero = 1'b0;
    case (it.func)
      FN_EXEC: begin
        // read plus write bypasses the ALU and the C bus entirely
        if (!(it.mem_read && it.mem_write)) begin
          case (it.b_select)
            BS_MDR:  bus = dp_regs[RG_MDR];
            BS_PC:   bus = dp_regs[RG_PC];
            BS_MBRS: bus = {{24{dp_mbr[7]}}, dp_mbr};
            BS_MBRU: bus = {24'd0, dp_mbr};
            BS_SP:   bus = dp_regs[RG_SP];
            BS_LV:   bus = dp_regs[RG_LV];
            BS_CPP:  bus = dp_regs[RG_CPP];
            BS_TOS:  bus = dp_regs[RG_TOS];
            BS_OPC:  bus = dp_regs[RG_OPC];
            default: bus = '0;
          endcase
          a = it.alu_ctrl[3] ? dp_regs[RG_H] : '0;
          b = it.alu_ctrl[2] ? bus : '0;
          if (it.alu_ctrl[1]) a = ~a;
          case (it.alu_ctrl[5:4])
            ALU_AND:  r = a & b;
            ALU_OR:   r = a | b;
            ALU_PASS: r = b;
            default:  r = a + b + 32'(it.alu_ctrl[0]);
          endcase
          // left shift wins when both shift bits are set
          if (it.alu_ctrl[7]) r = r << 8;
          else if (it.alu_ctrl[6]) r = {r[31], r[31:1]};
          neg  = r[31];
          zero = (r == '0);
          for (int k = 0; k < NUM_REGS; k++)
            if (it.c_enables[k]) dp_regs[k] = r;
        end
        if (dp_regs[RG_MAR] < 32'(MEM_WORDS)) begin
          addr = dp_regs[RG_MAR][MEM_AW-1:0];
          if (it.mem_read && it.mem_write) begin
            dp_mbr = it.alu_ctrl;
            dp_regs[RG_H] = {24'd0, it.alu_ctrl};
          end else if (it.mem_read) begin
            dp_regs[RG_MDR] = dp_mem[addr];
          end else if (it.mem_write) begin
            dp_mem[addr] = dp_regs[RG_MDR];
          end
        end
      end
      FN_LOAD_REG: begin
        if (it.load_index < LD_MBR) dp_regs[it.load_index] = it.load_value;
        else if (it.load_index == LD_MBR) dp_mbr = it.load_value[7:0];
        else if (it.load_index <= LD_H) dp_regs[it.load_index - 1] = it.load_value;
      end
      FN_LOAD_MEM: begin
        if (32'(it.load_index) < 32'(MEM_WORDS)) dp_mem[it.load_index] = it.load_value;
      end
      default: ;
    endcase
    snap = '0;
    for (int k = 0; k < NUM_REGS; k++)
      snap[32*k +: 32] = dp_regs[NUM_REGS-1-k];
    snap[295:288] = dp_mbr;
    snap[296]     = neg;
    snap[297]     = zero;
    return snap;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk) begin
    logic [303:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_states.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %h", $time, out_tdata);
        fail_count++;
      end else begin
        want = expected_states.pop_front();
        for (int k = 0; k < NUM_REGS; k++)
          check_field(word_names[k], want[32*k +: 32], out_tdata[32*k +: 32]);
        check_field("mbr_out", 32'(want[295:288]), 32'(out_tdata[295:288]));
        check_field("neg_flag", 32'(want[296]), 32'(out_tdata[296]));
        check_field("zero_flag", 32'(want[297]), 32'(out_tdata[297]));
      end
    end
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Called right after a rising edge; returns right after the accepting edge
  // with in_tvalid still high.
  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.func;
    in_tdata  <= {5'd0, it.load_value, it.load_index, it.b_select, it.mem_read,
                  it.mem_write, it.c_enables, it.alu_ctrl};
    do @(posedge clk); while (!in_tready);
    expected_states.push_back(step_datapath(it));
  endtask

  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_states.size() != 0) @(posedge clk);
  endtask

  task automatic apply_reset();
    for (int k = 0; k < NUM_REGS; k++) dp_regs[k] = '0;
    for (int k = 0; k < MEM_WORDS; k++) dp_mem[k] = '0;
    dp_mbr = '0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  endtask

  task automatic test_preloads();
    send_item(mk_load(FN_LOAD_REG, LD_MAR, 32'd15));
    send_item(mk_load(FN_LOAD_REG, LD_MDR, 32'hFFFF_FFFF));
    send_item(mk_load(FN_LOAD_REG, LD_PC,  32'h8000_0000));
    send_item(mk_load(FN_LOAD_REG, LD_MBR, 32'h1234_5680));
    send_item(mk_load(FN_LOAD_REG, LD_SP,  32'd1));
    send_item(mk_load(FN_LOAD_REG, LD_LV,  32'h7FFF_FFFF));
    send_item(mk_load(FN_LOAD_REG, LD_CPP, 32'hA5A5_A5A5));
    send_item(mk_load(FN_LOAD_REG, LD_TOS, 32'h5A5A_5A5A));
    send_item(mk_load(FN_LOAD_REG, LD_H,   32'h0000_0100));
    // index past H is dropped
    send_item(mk_load(FN_LOAD_REG, 4'd15,  32'hDEAD_BEEF));
    send_item(mk_load(FN_LOAD_MEM, 4'd0,   32'hFFFF_FFFF));
    send_item(mk_load(FN_LOAD_MEM, 4'd15,  32'h1357_9BDF));
  endtask

  task automatic test_alu_ops();
    send_item(mk_exec(alu_word(0, 0, ALU_AND, 1, 1, 0, 0), 9'(1 << RG_OPC), 0, 0, BS_MDR));
    send_item(mk_exec(alu_word(0, 0, ALU_OR, 1, 1, 1, 0), 9'(1 << RG_TOS), 0, 0, BS_PC));
    send_item(mk_exec(alu_word(0, 0, ALU_PASS, 0, 1, 0, 0), 9'(1 << RG_CPP), 0, 0, BS_MBRS));
    send_item(mk_exec(alu_word(0, 0, ALU_PASS, 0, 1, 0, 0), 9'(1 << RG_LV), 0, 0, BS_MBRU));
    send_item(mk_exec(alu_word(0, 0, ALU_ADD, 1, 1, 0, 1), 9'(1 << RG_H), 0, 0, BS_LV));
    send_item(mk_exec(alu_word(0, 1, ALU_PASS, 0, 1, 0, 0), 9'(1 << RG_PC), 0, 0, BS_PC));
    send_item(mk_exec(alu_word(1, 1, ALU_PASS, 0, 1, 0, 0), 9'h1FE, 0, 0, BS_OPC));
    // B select past OPC carries zero: zero flag, nothing written
    send_item(mk_exec(alu_word(0, 0, ALU_ADD, 0, 1, 0, 0), 9'd0, 0, 0, 4'd15));
  endtask

  task automatic test_memory();
    send_item(mk_exec(8'h00, 9'd0, 0, 1, BS_MDR));
    send_item(mk_exec(alu_word(0, 0, ALU_PASS, 0, 1, 0, 0), 9'(1 << RG_MDR), 1, 0, BS_SP));
    send_item(mk_exec(8'hC3, 9'h1FF, 1, 1, BS_TOS));
    send_item(mk_load(FN_LOAD_REG, LD_MAR, 32'd16));
    send_item(mk_exec(8'h5A, 9'd0, 1, 1, BS_MDR));
    send_item(mk_exec(alu_word(0, 0, ALU_PASS, 0, 1, 0, 0), 9'(1 << RG_OPC), 0, 1, BS_SP));
    send_item(mk_load(FN_IDLE, 4'd0, 32'hFFFF_FFFF));
  endtask

  function automatic item_t rand_item();
    item_t it;
    int    pick;
    it = item_t'(61'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      it.func = FN_EXEC;
      // keep MAR mostly untouched so memory stays reachable
      if ($urandom_range(0, 3) != 0) it.c_enables[RG_MAR] = 1'b0;
    end else if (pick < 82) begin
      it.func = FN_LOAD_REG;
      if ($urandom_range(0, 9) < 4) begin
        it.load_index = LD_MAR;
        it.load_value = $urandom_range(0, 20);
      end
    end else if (pick < 96) begin
      it.func = FN_LOAD_MEM;
    end else begin
      it.func = FN_IDLE;
    end
    return it;
  endfunction

  task automatic test_random(int count);
    for (int n = 0; n < count; n++) send_item(rand_item());
  endtask

  initial begin
    fail_count    = 0;
    cycles        = 0;
    send_idle_pct = 36;
    recv_idle_pct = 75;
    apply_reset();
    test_preloads();
    test_alu_ops();
    test_memory();
    test_random(300);
    // hold the sender until the pipe is empty
    wait_results_drained();
    send_idle_pct = 75;
    recv_idle_pct = 36;
    test_random(300);
    wait_results_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(325);
    wait_results_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/msd_pkg.sv
sv/msd_alu.sv
sv/msd_state.sv
sv/microprogrammed_stack_datapath.sv
dv/microprogrammed_stack_datapath_test.sv
